/* rtl/assert_macros.svh */
// Assertion macros shared by the whitelist table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition at every rising clock edge outside of reset.
`define MWL_ASSERT(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define MWL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/mwl_pkg.sv */
// Shared types and constants for the MAC whitelist table.
`timescale 1ns / 1ps

package mwl_pkg;

    localparam int MAC_W          = 48;
    localparam int REQ_W          = 2;
    localparam int LIST_COUNT_W   = 5;
    localparam int BYTE_W         = 8;
    localparam int DEF_SLOTS      = 10;
    localparam int DEF_ADDR_BYTES = 6;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_CHECK = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ADD   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [MAC_W-1:0] mac_addr;
    } in_t;

    typedef struct packed {
        logic                    found;
        logic [LIST_COUNT_W-1:0] list_count;
    } out_t;

    // Decoded request as it travels from the front end to the back end.
    typedef struct packed {
        logic             lookup;
        logic             add;
        logic             clear;
        logic [MAC_W-1:0] mac;
    } cmd_t;

endpackage

/* rtl/mac_whitelist_round_robin_table_core.sv */
// Top level of the MAC whitelist table with round-robin replacement.
`timescale 1ns / 1ps

// This block keeps a whitelist of SLOTS MAC addresses of ADDR_BYTES bytes each and
// answers one request per transaction: a check reports whether the address matches
// one of the stored entries, an add stores it in the next slot in round-robin order
// unless it is already present, and a clear empties the list. Every request, the
// unused code included, yields exactly one result transaction carrying the found
// flag and the stored count, which runs through 0 to 2*SLOTS-1 so that old entries
// are replaced in order. Addresses compare like a bounded string compare, first byte
// in the high bits, and an equal zero byte ends the compare as a match. The block
// sustains one transaction per clock cycle while results are taken: the front end
// registers each request into a two-entry queue, and the back end compares it against
// all slots in parallel and updates the count and the entry in the same cycle, so the
// count update is the loop that sets the rate. The result valid is registered: a
// request is first written into the queue, and the back end loads the result register
// as it pops it. While a result waits, the queue keeps accepting up to two requests,
// and a taken waiting result lets the next queued request through in that cycle.
module mac_whitelist_round_robin_table_core #(
    parameter int SLOTS      = mwl_pkg::DEF_SLOTS,
    parameter int ADDR_BYTES = mwl_pkg::DEF_ADDR_BYTES
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  mwl_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output mwl_pkg::out_t m_data
);

    // Decoded requests handed from the front end to the back end.
    logic          deq_valid;
    logic          deq_ready;
    mwl_pkg::cmd_t deq_cmd;

    mwl_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .deq_valid (deq_valid),
        .deq_ready (deq_ready),
        .deq_cmd   (deq_cmd)
    );

    // The back end owns the entry cells and the count; it only ever looks at
    // slots below the count, so entries never need clearing.
    mwl_back #(
        .SLOTS      (SLOTS),
        .ADDR_BYTES (ADDR_BYTES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .deq_valid (deq_valid),
        .deq_ready (deq_ready),
        .deq_cmd   (deq_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

/* rtl/mwl_front.sv */
// Front end: accepts requests, decodes them and queues them for the back end.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mwl_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  mwl_pkg::in_t  s_data,
    output logic          deq_valid,
    input  logic          deq_ready,
    output mwl_pkg::cmd_t deq_cmd
);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    mwl_pkg::cmd_t queue_mem [QUEUE_DEPTH];

    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] occ_reg, occ_next;

    mwl_pkg::cmd_t new_cmd;
    logic          push;
    logic          pop;

    // Classify the request; the unused code decodes to a request that does nothing.
    always_comb begin
        new_cmd.mac    = s_data.mac_addr;
        new_cmd.add    = (s_data.req_type == mwl_pkg::REQ_ADD);
        new_cmd.clear  = (s_data.req_type == mwl_pkg::REQ_CLEAR);
        new_cmd.lookup = (s_data.req_type == mwl_pkg::REQ_CHECK) ||
                         (s_data.req_type == mwl_pkg::REQ_ADD);
    end

    assign s_ready   = (occ_reg != QCNT_W'(QUEUE_DEPTH));
    assign deq_valid = (occ_reg != '0);
    assign deq_cmd   = queue_mem[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = deq_valid && deq_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        occ_next = occ_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            occ_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            occ_reg    <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= new_cmd;
        end
    end

    `MWL_ASSERT(a_occ_bound, aclk, aresetn, occ_reg <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")

endmodule

/* rtl/mwl_back.sv */
// Back end: parallel entry compare, round-robin replacement and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mwl_back #(
    parameter int SLOTS      = mwl_pkg::DEF_SLOTS,
    parameter int ADDR_BYTES = mwl_pkg::DEF_ADDR_BYTES
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          deq_valid,
    output logic          deq_ready,
    input  mwl_pkg::cmd_t deq_cmd,
    output logic          m_valid,
    input  logic          m_ready,
    output mwl_pkg::out_t m_data
);

    localparam int ENTRY_W = mwl_pkg::BYTE_W * ADDR_BYTES;
    localparam int CNT_W   = $clog2(2 * SLOTS);
    localparam int IDX_W   = $clog2(SLOTS);
    localparam int WIDE_W  = mwl_pkg::MAC_W + ENTRY_W;
    localparam int CWIDE_W = CNT_W + mwl_pkg::LIST_COUNT_W;

    logic [ENTRY_W-1:0] entry_reg [SLOTS];

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              m_valid_reg, m_valid_next;
    mwl_pkg::out_t     m_data_reg, m_data_next;

    logic [WIDE_W-1:0]  mac_wide;
    logic [ENTRY_W-1:0] mac_e;
    logic [SLOTS-1:0]   hit_vec;
    logic               hit;
    logic               pop;
    logic               wr_en;
    logic [CNT_W-1:0]   slot_full;
    logic [IDX_W-1:0]   slot_idx;
    logic [CWIDE_W-1:0] cnt_wide;

    assign mac_wide  = WIDE_W'(deq_cmd.mac);
    assign mac_e     = mac_wide[ENTRY_W-1:0];
    assign deq_ready = !m_valid_reg || m_ready;
    assign pop       = deq_valid && deq_ready;

    // Each slot compares byte by byte from the first byte; an equal zero byte ends
    // the compare as a match. Only slots below the count hold written entries.
    always_comb begin
        logic       done;
        logic       match;
        logic [7:0] xb;
        logic [7:0] yb;
        for (int i = 0; i < SLOTS; i++) begin
            done  = 1'b0;
            match = 1'b1;
            for (int k = ADDR_BYTES - 1; k >= 0; k--) begin
                xb = mac_e[mwl_pkg::BYTE_W*k +: 8];
                yb = entry_reg[i][mwl_pkg::BYTE_W*k +: 8];
                if (!done) begin
                    if (xb != yb) begin
                        done  = 1'b1;
                        match = 1'b0;
                    end else if (xb == 8'd0) begin
                        done = 1'b1;
                    end
                end
            end
            hit_vec[i] = match && (CNT_W'(i) < cnt_reg);
        end
    end

    assign hit       = |hit_vec;
    assign slot_full = (cnt_reg >= CNT_W'(SLOTS)) ? cnt_reg - CNT_W'(SLOTS) : cnt_reg;
    assign slot_idx  = slot_full[IDX_W-1:0];
    assign wr_en     = pop && deq_cmd.add && !hit;

    always_comb begin
        cnt_next = cnt_reg;
        if (pop) begin
            if (deq_cmd.clear) begin
                cnt_next = '0;
            end else if (deq_cmd.add && !hit) begin
                cnt_next = (cnt_reg == CNT_W'(2 * SLOTS - 1)) ? CNT_W'(SLOTS)
                                                              : cnt_reg + 1'b1;
            end
        end
    end

    assign cnt_wide = CWIDE_W'(cnt_next);

    always_comb begin
        m_data_next            = m_data_reg;
        m_valid_next           = m_valid_reg && !m_ready;
        if (pop) begin
            m_valid_next           = 1'b1;
            m_data_next.found      = deq_cmd.lookup && hit;
            m_data_next.list_count = cnt_wide[mwl_pkg::LIST_COUNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (wr_en) begin
            entry_reg[slot_idx] <= mac_e;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `MWL_ASSERT(a_cnt_range, aclk, aresetn, cnt_reg <= CNT_W'(2 * SLOTS - 1), "count out of range")
    `MWL_ASSERT_NEXT(a_clear_result, aclk, aresetn, pop && deq_cmd.clear, m_valid_reg && (m_data_reg.list_count == '0) && !m_data_reg.found, "clear result wrong")
    `MWL_ASSERT_NEXT(a_hit_keeps_cnt, aclk, aresetn, pop && deq_cmd.add && hit, cnt_reg == $past(cnt_reg), "add of present address changed count")

endmodule
